@@ src/chip8_instruction_execute_defines.svh @@
// Assertion macros for the CHIP-8 execute block
`ifndef CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CHIP8_INSTRUCTION_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS
`define C8X_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define C8X_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define C8X_ASSERT_IMP(lbl, ante, cons)
`define C8X_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ src/c8x_pkg.sv @@
package c8x_pkg;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  localparam logic [7:0] MISC_LDDT  = 8'h07;
  localparam logic [7:0] MISC_WKEY  = 8'h0A;
  localparam logic [7:0] MISC_SETDT = 8'h15;
  localparam logic [7:0] MISC_SETST = 8'h18;
  localparam logic [7:0] MISC_ADDI  = 8'h1E;

  localparam logic [3:0] FLAG_REG = 4'hF;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        key_taken;
    logic        clear_req;
    logic        draw_req;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic [15:0] draw_addr;
    logic        unknown_op;
    logic        stack_fault;
  } result_t;

endpackage

@@ src/c8x_ram.sv @@
module c8x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

@@ src/chip8_instruction_execute.sv @@
// CHIP-8 instruction execute stage.
// Input channel (in_*): one instruction word fetched at the pc last reported,
// plus pending key state and a random byte. Output channel (out_*): one
// result per instruction with the next fetch address and side requests
// (clear, draw, key consumed, unknown opcode, stack fault).
// Both channels: valid/stall, a request moves when valid is high and stall low.
// The instruction is registered into the execute stage, its result into the
// output register (single execute stage, the stack read is issued early).
// Throughput: one instruction per cycle unless stalled; the stack read address
// is taken from the depth the executing instruction leaves, with a bypass of
// a same-cycle push, so calls and returns follow each other without bubbles.
// When out_stall is high the output register holds; one more request is
// buffered in the execute stage and then in_stall rises.
// Reset: pc = START_ADDR, V0..VF, I, DT, ST and stack depth cleared; the
// return stack memory is not cleared (only entries below depth are read).
module chip8_instruction_execute
  import c8x_pkg::*;
#(
  parameter int START_ADDR  = 512,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_instr_word,
  input  logic        in_key_valid,
  input  logic [3:0]  in_key_code,
  input  logic [7:0]  in_rnd_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_next_pc,
  output logic        out_key_taken,
  output logic        out_clear_req,
  output logic        out_draw_req,
  output logic [7:0]  out_draw_x,
  output logic [7:0]  out_draw_y,
  output logic [3:0]  out_draw_rows,
  output logic [15:0] out_draw_addr,
  output logic        out_unknown_op,
  output logic        out_stack_fault
);

  `include "chip8_instruction_execute_defines.svh"

  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  logic        s1_valid_r;
  logic [15:0] s1_instr_r;
  logic        s1_kv_r;
  logic [3:0]  s1_kc_r;
  logic [7:0]  s1_rb_r;
  logic        s1_go;
  logic        accept;

  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  gp_r [16];
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  dt_r, dt_nxt;
  logic [7:0]  st_r, st_nxt;
  logic [DW-1:0] depth_r, depth_exec, depth_nxt;

  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [15:0]    stk_q, stk_top;
  logic           fwd_r;
  logic [15:0]    fwd_data_r;

  logic        out_valid_r;
  result_t     out_r, res;

  logic [3:0]  x, y, n, op;
  logic [7:0]  kk, vx, vy;
  logic [15:0] nnn, seq, skp;
  logic        wx_en, wf_en, flag_first;
  logic [7:0]  wx_val, wf_val;
  logic [8:0]  sum;

  assign accept   = in_valid && !in_stall;
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;

  assign op  = s1_instr_r[15:12];
  assign x   = s1_instr_r[11:8];
  assign y   = s1_instr_r[7:4];
  assign n   = s1_instr_r[3:0];
  assign kk  = s1_instr_r[7:0];
  assign nnn = {4'h0, s1_instr_r[11:0]};
  assign vx  = gp_r[x];
  assign vy  = gp_r[y];
  assign seq = pc_r + 16'd2;
  assign skp = pc_r + 16'd4;
  assign sum = {1'b0, vx} + {1'b0, vy};
  assign stk_top = fwd_r ? fwd_data_r : stk_q;

  always_comb begin
    res        = '0;
    res.next_pc = seq;
    idx_nxt    = idx_r;
    dt_nxt     = dt_r;
    st_nxt     = st_r;
    depth_exec = depth_r;
    stk_we     = 1'b0;
    wx_en      = 1'b0;
    wx_val     = 8'h00;
    wf_en      = 1'b0;
    wf_val     = 8'h00;
    flag_first = 1'b1;
    case (op)
      OP_SYS: begin
        if (kk == SYS_CLS) begin
          res.clear_req = 1'b1;
        end else if (kk == SYS_RET) begin
          if (depth_r == '0) begin
            res.next_pc     = pc_r;
            res.stack_fault = 1'b1;
          end else begin
            depth_exec  = depth_r - DW'(1);
            res.next_pc = stk_top;
          end
        end else begin
          res.next_pc    = pc_r;
          res.unknown_op = 1'b1;
        end
      end
      OP_JP: res.next_pc = nnn;
      OP_CALL: begin
        if (depth_r >= DEPTH_MAX) begin
          res.next_pc     = pc_r;
          res.stack_fault = 1'b1;
        end else begin
          stk_we      = 1'b1;
          depth_exec  = depth_r + DW'(1);
          res.next_pc = nnn;
        end
      end
      OP_SE:   if (vx == kk) res.next_pc = skp;
      OP_SNE:  if (vx != kk) res.next_pc = skp;
      OP_SER:  if (vx == vy) res.next_pc = skp;
      OP_SNER: if (vx != vy) res.next_pc = skp;
      OP_LD: begin
        wx_en  = 1'b1;
        wx_val = kk;
      end
      OP_ADD: begin
        wx_en  = 1'b1;
        wx_val = vx + kk;
      end
      OP_ALU: begin
        wx_en = 1'b1;
        case (n)
          ALU_MOV: wx_val = vy;
          ALU_OR:  wx_val = vx | vy;
          ALU_AND: wx_val = vx & vy;
          ALU_XOR: wx_val = vx ^ vy;
          ALU_ADD: begin
            wx_val     = sum[7:0];
            wf_en      = 1'b1;
            wf_val     = {7'd0, sum[8]};
            flag_first = 1'b0;
          end
          ALU_SUB: begin
            wx_val = vx - vy;
            wf_en  = 1'b1;
            wf_val = {7'd0, vx > vy};
          end
          ALU_SHR: begin
            wx_val = {1'b0, vx[7:1]};
            wf_en  = 1'b1;
            wf_val = {7'd0, vx[0]};
          end
          ALU_SUBN: begin
            wx_val = vy - vx;
            wf_en  = 1'b1;
            wf_val = {7'd0, vy > vx};
          end
          ALU_SHL: begin
            wx_val = {vx[6:0], 1'b0};
            wf_en  = 1'b1;
            wf_val = {7'd0, vx[7]};
          end
          default: begin
            wx_en          = 1'b0;
            res.next_pc    = pc_r;
            res.unknown_op = 1'b1;
          end
        endcase
      end
      OP_LDI:  idx_nxt = nnn;
      OP_JPV0: res.next_pc = nnn + {8'h00, gp_r[0]};
      OP_RND: begin
        wx_en  = 1'b1;
        wx_val = s1_rb_r & kk;
      end
      OP_DRW: begin
        res.draw_req  = 1'b1;
        res.draw_x    = vx;
        res.draw_y    = vy;
        res.draw_rows = n;
        res.draw_addr = idx_r;
      end
      OP_MISC: begin
        case (kk)
          MISC_LDDT: begin
            wx_en  = 1'b1;
            wx_val = dt_r;
          end
          MISC_WKEY: begin
            if (s1_kv_r) begin
              wx_en         = 1'b1;
              wx_val        = {4'h0, s1_kc_r};
              res.key_taken = 1'b1;
            end else begin
              res.next_pc = pc_r;
            end
          end
          MISC_SETDT: dt_nxt = vx;
          MISC_SETST: st_nxt = vx;
          MISC_ADDI:  idx_nxt = idx_r + {8'h00, vx};
          default: begin
            res.next_pc    = pc_r;
            res.unknown_op = 1'b1;
          end
        endcase
      end
      default: begin
        res.next_pc    = pc_r;
        res.unknown_op = 1'b1;
      end
    endcase
  end

  assign pc_nxt    = s1_go ? res.next_pc : pc_r;
  assign depth_nxt = s1_go ? depth_exec : depth_r;
  assign stk_waddr = SAW'(depth_r);
  assign stk_raddr = SAW'(depth_nxt - DW'(1));

  c8x_ram #(
    .WIDTH(16),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .wr_en    (s1_go && stk_we),
    .wr_addr  (stk_waddr),
    .wr_data  (seq),
    .rd_addr  (stk_raddr),
    .rd_data_r(stk_q)
  );

  always_ff @(posedge clk) begin
    fwd_r      <= s1_go && stk_we && (stk_waddr == stk_raddr);
    fwd_data_r <= seq;
    if (accept) begin
      s1_instr_r <= in_instr_word;
      s1_kv_r    <= in_key_valid;
      s1_kc_r    <= in_key_code;
      s1_rb_r    <= in_rnd_byte;
    end
    if (s1_go) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= 16'(START_ADDR);
      idx_r       <= '0;
      dt_r        <= '0;
      st_r        <= '0;
      depth_r     <= '0;
      for (int i = 0; i < 16; i++) begin
        gp_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pc_r    <= pc_nxt;
      depth_r <= depth_nxt;
      if (s1_go) begin
        idx_r <= idx_nxt;
        dt_r  <= dt_nxt;
        st_r  <= st_nxt;
        if (flag_first) begin
          if (wf_en) gp_r[FLAG_REG] <= wf_val;
          if (wx_en) gp_r[x] <= wx_val;
        end else begin
          if (wx_en) gp_r[x] <= wx_val;
          if (wf_en) gp_r[FLAG_REG] <= wf_val;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_r.next_pc;
  assign out_key_taken   = out_r.key_taken;
  assign out_clear_req   = out_r.clear_req;
  assign out_draw_req    = out_r.draw_req;
  assign out_draw_x      = out_r.draw_x;
  assign out_draw_y      = out_r.draw_y;
  assign out_draw_rows   = out_r.draw_rows;
  assign out_draw_addr   = out_r.draw_addr;
  assign out_unknown_op  = out_r.unknown_op;
  assign out_stack_fault = out_r.stack_fault;

  `C8X_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= DEPTH_MAX)
  `C8X_ASSERT_IMP(a_stall_only_busy, in_stall, s1_valid_r)
  `C8X_ASSERT_IMP(a_pc_matches_out, out_valid_r, pc_r == out_r.next_pc)
  `C8X_ASSERT_NXT(a_fault_keeps_depth, s1_go && res.stack_fault, $stable(depth_r))

endmodule

@@ test/chip8_instruction_execute_test.sv @@
`timescale 1ns / 100ps

module chip8_instruction_execute_test;
  import c8x_pkg::*;

  localparam int START_PC = 512;
  localparam int MAX_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] word;
    logic        key_valid;
    logic [3:0]  key_code;
    logic [7:0]  rnd_byte;
  } instr_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [15:0] in_instr_word;
  logic in_key_valid;
  logic [3:0] in_key_code;
  logic [7:0] in_rnd_byte;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_next_pc;
  logic out_key_taken;
  logic out_clear_req;
  logic out_draw_req;
  logic [7:0] out_draw_x;
  logic [7:0] out_draw_y;
  logic [3:0] out_draw_rows;
  logic [15:0] out_draw_addr;
  logic out_unknown_op;
  logic out_stack_fault;

  instr_t pending_instrs[$];
  result_t expected_results[$];

  // machine state mirror
  logic [15:0] pc_m;
  logic [7:0] v_m[16];
  logic [15:0] i_m;
  logic [7:0] dt_m;
  logic [7:0] st_m;
  logic [15:0] stack_m[MAX_DEPTH];
  int depth_m;

  int errors;
  int cycles;
  int accepted;
  int checked;
  int draws_seen;
  int faults_seen;
  bit stim_done;
  bit quiet_tail;
  int send_gap;
  int recv_gap;
  int hold_off;

  chip8_instruction_execute #(
    .START_ADDR(START_PC),
    .STACK_DEPTH(MAX_DEPTH)
  ) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t execute_instr(instr_t it);
    result_t r;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] kk;
    logic [7:0] vx;
    logic [7:0] vy;
    logic [15:0] seq;
    logic [8:0] sum;
    x = it.word[11:8];
    y = it.word[7:4];
    kk = it.word[7:0];
    vx = v_m[x];
    vy = v_m[y];
    seq = pc_m + 16'd2;
    r = '0;
    r.next_pc = seq;
    case (it.word[15:12])
      OP_SYS: begin
        if (kk == SYS_CLS) begin
          r.clear_req = 1'b1;
        end else if (kk == SYS_RET) begin
          if (depth_m == 0) begin
            r.next_pc = pc_m;
            r.stack_fault = 1'b1;
          end else begin
            depth_m--;
            r.next_pc = stack_m[depth_m];
          end
        end else begin
          r.next_pc = pc_m;
          r.unknown_op = 1'b1;
        end
      end
      OP_JP: r.next_pc = {4'h0, it.word[11:0]};
      OP_CALL: begin
        if (depth_m >= MAX_DEPTH) begin
          r.next_pc = pc_m;
          r.stack_fault = 1'b1;
        end else begin
          stack_m[depth_m] = seq;
          depth_m++;
          r.next_pc = {4'h0, it.word[11:0]};
        end
      end
      OP_SE: if (vx == kk) r.next_pc = pc_m + 16'd4;
      OP_SNE: if (vx != kk) r.next_pc = pc_m + 16'd4;
      OP_SER: if (vx == vy) r.next_pc = pc_m + 16'd4;
      OP_LD: v_m[x] = kk;
      OP_ADD: v_m[x] = vx + kk;
      OP_ALU: begin
        case (it.word[3:0])
          ALU_MOV: v_m[x] = vy;
          ALU_OR: v_m[x] = vx | vy;
          ALU_AND: v_m[x] = vx & vy;
          ALU_XOR: v_m[x] = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            v_m[x] = sum[7:0];
            v_m[FLAG_REG] = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            v_m[FLAG_REG] = {7'd0, vx > vy};
            v_m[x] = vx - vy;
          end
          ALU_SHR: begin
            v_m[FLAG_REG] = {7'd0, vx[0]};
            v_m[x] = vx >> 1;
          end
          ALU_SUBN: begin
            v_m[FLAG_REG] = {7'd0, vy > vx};
            v_m[x] = vy - vx;
          end
          ALU_SHL: begin
            v_m[FLAG_REG] = {7'd0, vx[7]};
            v_m[x] = vx << 1;
          end
          default: begin
            r.next_pc = pc_m;
            r.unknown_op = 1'b1;
          end
        endcase
      end
      OP_SNER: if (vx != vy) r.next_pc = pc_m + 16'd4;
      OP_LDI: i_m = {4'h0, it.word[11:0]};
      OP_JPV0: r.next_pc = {4'h0, it.word[11:0]} + {8'h00, v_m[0]};
      OP_RND: v_m[x] = it.rnd_byte & kk;
      OP_DRW: begin
        r.draw_req = 1'b1;
        r.draw_x = vx;
        r.draw_y = vy;
        r.draw_rows = it.word[3:0];
        r.draw_addr = i_m;
      end
      OP_MISC: begin
        case (kk)
          MISC_LDDT: v_m[x] = dt_m;
          MISC_WKEY: begin
            if (it.key_valid) begin
              v_m[x] = {4'h0, it.key_code};
              r.key_taken = 1'b1;
            end else begin
              r.next_pc = pc_m;
            end
          end
          MISC_SETDT: dt_m = vx;
          MISC_SETST: st_m = vx;
          MISC_ADDI: i_m = i_m + {8'h00, vx};
          default: begin
            r.next_pc = pc_m;
            r.unknown_op = 1'b1;
          end
        endcase
      end
      default: begin
        r.next_pc = pc_m;
        r.unknown_op = 1'b1;
      end
    endcase
    pc_m = r.next_pc;
    return r;
  endfunction

  function automatic instr_t make_instr(logic [15:0] word);
    instr_t it;
    it.word = word;
    it.key_valid = 1'($urandom);
    it.key_code = 4'($urandom);
    it.rnd_byte = 8'($urandom);
    return it;
  endfunction

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 15))
      0: w[15:12] = OP_LD;
      1: w[15:12] = OP_ADD;
      2, 3: w[15:12] = OP_ALU;
      4: w = {OP_CALL, w[11:0]};
      5: w = {OP_SYS, w[11:8], SYS_RET};
      6: w = {OP_MISC, w[11:8], MISC_WKEY};
      7: w = {OP_MISC, w[11:8], MISC_SETDT};
      8: w = {OP_MISC, w[11:8], MISC_SETST};
      9: w = {OP_MISC, w[11:8], MISC_ADDI};
      10: w = {OP_MISC, w[11:8], MISC_LDDT};
      11: w = {OP_SE, w[11:8], 8'($urandom_range(0, 3))};
      12: w = {OP_SYS, w[11:8], SYS_CLS};
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic [15:0] directed[$];
    directed = '{
      16'h00E0, 16'h0FE0, 16'h00EE, 16'h0123, 16'h60FF, 16'h61FF, 16'h8014,
      16'h8F14, 16'h6280, 16'h8216, 16'h823E, 16'h8125, 16'h8F17, 16'h8008,
      16'h800F, 16'hE19E, 16'hF029, 16'hF365, 16'hAFFF, 16'hF11E, 16'hD12F,
      16'hC0FF, 16'hF00A, 16'hF115, 16'hF218
    };
    foreach (directed[k]) pending_instrs = {pending_instrs, make_instr(directed[k])};
    // fill the stack past its limit, then unwind past empty
    for (int k = 0; k < MAX_DEPTH + 2; k++)
      pending_instrs = {pending_instrs, make_instr({OP_CALL, 12'($urandom)})};
    for (int k = 0; k < MAX_DEPTH + 2; k++)
      pending_instrs = {pending_instrs, make_instr({OP_SYS, 4'($urandom), SYS_RET})};
    pending_instrs = {pending_instrs, make_instr(16'h5AB7)};
    pending_instrs = {pending_instrs, make_instr(16'h9AB7)};
    pending_instrs = {pending_instrs, make_instr(16'hBFFF)};
    pending_instrs = {pending_instrs, make_instr(16'h4000)};
    pending_instrs = {pending_instrs, make_instr(16'h1FFE)};
    for (int k = 0; k < 1600; k++)
      pending_instrs = {pending_instrs, make_instr(random_word())};
  end

  initial begin
    rst_n = 1'b0;
    pc_m = 16'(START_PC);
    i_m = '0;
    dt_m = '0;
    st_m = '0;
    depth_m = 0;
    foreach (v_m[k]) v_m[k] = '0;
    foreach (stack_m[k]) stack_m[k] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_instr_word <= '0;
      in_key_valid <= 1'b0;
      in_key_code <= '0;
      in_rnd_byte <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        instr_t cur;
        cur = pending_instrs.pop_front();
        expected_results = {expected_results, execute_instr(cur)};
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_instrs.size() > 0) begin
          instr_t nxt;
          nxt = pending_instrs[0];
          in_valid <= 1'b1;
          in_instr_word <= nxt.word;
          in_key_valid <= nxt.key_valid;
          in_key_code <= nxt.key_code;
          in_rnd_byte <= nxt.rnd_byte;
          if (!quiet_tail && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off early on so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 0;
    end else if (accepted >= 100 && hold_off == 0) begin
      hold_off <= 60;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
    end else if (hold_off == 1) begin
      hold_off <= -1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected request: next_pc %h", out_next_pc);
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (out_next_pc !== e.next_pc) begin
            $error("next_pc exp %h got %h", e.next_pc, out_next_pc); errors++;
          end
          if (out_key_taken !== e.key_taken) begin
            $error("key_taken exp %b got %b", e.key_taken, out_key_taken); errors++;
          end
          if (out_clear_req !== e.clear_req) begin
            $error("clear_req exp %b got %b", e.clear_req, out_clear_req); errors++;
          end
          if (out_draw_req !== e.draw_req) begin
            $error("draw_req exp %b got %b", e.draw_req, out_draw_req); errors++;
          end
          if (out_draw_x !== e.draw_x) begin
            $error("draw_x exp %h got %h", e.draw_x, out_draw_x); errors++;
          end
          if (out_draw_y !== e.draw_y) begin
            $error("draw_y exp %h got %h", e.draw_y, out_draw_y); errors++;
          end
          if (out_draw_rows !== e.draw_rows) begin
            $error("draw_rows exp %h got %h", e.draw_rows, out_draw_rows); errors++;
          end
          if (out_draw_addr !== e.draw_addr) begin
            $error("draw_addr exp %h got %h", e.draw_addr, out_draw_addr); errors++;
          end
          if (out_unknown_op !== e.unknown_op) begin
            $error("unknown_op exp %b got %b", e.unknown_op, out_unknown_op); errors++;
          end
          if (out_stack_fault !== e.stack_fault) begin
            $error("stack_fault exp %b got %b", e.stack_fault, out_stack_fault); errors++;
          end
          draws_seen <= draws_seen + e.draw_req;
          faults_seen <= faults_seen + e.stack_fault;
        end
        checked <= checked + 1;
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= (recv_gap > 1);
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 19);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout");
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    accepted = 0;
    checked = 0;
    draws_seen = 0;
    faults_seen = 0;
    stim_done = 1'b0;
    quiet_tail = 1'b0;
    in_valid = 1'b0;
    in_instr_word = '0;
    in_key_valid = 1'b0;
    in_key_code = '0;
    in_rnd_byte = '0;
    out_stall = 1'b0;
    @(posedge rst_n);
    wait (pending_instrs.size() < 200);
    quiet_tail = 1'b1;
    wait (pending_instrs.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("%0d instructions executed, %0d results checked", accepted, checked);
    $display("%0d draw requests and %0d stack faults among them", draws_seen, faults_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
